/* rtl/pgo_pkg.sv */
// ----------------------------------------------------------------------------
// pgo_pkg
// Shared types, codes and the round-half-to-even helper of the packed 12-bit
// gain/offset correction block.
// ----------------------------------------------------------------------------
package pgo_pkg;

    // Command codes
    localparam logic CMD_PROCESS = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;

    // Unpacking of the middle byte
    localparam logic [7:0] NIB_LO    = 8'h0f;
    localparam logic [7:0] NIB_HI    = 8'hf0;
    localparam int         NIB_SHIFT = 4;

    // Half of one unit at a 16-bit fraction
    localparam logic [15:0] RND_HALF = 16'h8000;

    // Saturation limits of the 24-bit coefficient formats
    localparam logic signed [23:0] COEF_MAX = 24'sh7fffff;
    localparam logic signed [23:0] COEF_MIN = 24'sh800000;

    // Reset value of the page gain, 1.0 in Q8.16
    localparam logic signed [23:0] AGC_RESET = 24'sh010000;

    // Controls of one lane for the current cycle
    typedef struct packed {
        logic s3_en;   // lane stage 3 takes a new pixel; table data is taken on rd_en
        logic rd_en;   // table read for a process item
        logic wr_en;   // table write for a load item
        logic s4_en;   // lane stage 4 takes the new sum
    } pgo_lane_ctl_t;

    // Stage enables of the coefficient scaler
    typedef struct packed {
        logic s1_en;
        logic s2_en;
    } pgo_scale_ctl_t;

    // v / 2^16 rounded half to even, also for negative values
    function automatic logic signed [32:0] rne_shr16(input logic signed [47:0] v);
        logic [31:0] q;
        logic [15:0] r;
        logic        inc;
        q   = v[47:16];
        r   = v[15:0];
        inc = (r > RND_HALF) || ((r == RND_HALF) && q[0]);
        return {q[31], q} + {32'b0, inc};
    endfunction

endpackage

/* rtl/pgo_in_if.sv */
// ----------------------------------------------------------------------------
// pgo_in_if
// Input channel: one command item per handshake, valid/ready.
// ----------------------------------------------------------------------------
interface pgo_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic        [23:0] packed_pair;
    logic               line_start;
    logic        [11:0] coef_index;
    logic signed [23:0] coef_gain;
    logic signed [23:0] coef_offset;

    modport source (
        output valid, cmd, packed_pair, line_start, coef_index, coef_gain, coef_offset,
        input  ready
    );

    modport sink (
        input  valid, cmd, packed_pair, line_start, coef_index, coef_gain, coef_offset,
        output ready
    );
endinterface

/* rtl/pgo_out_if.sv */
// ----------------------------------------------------------------------------
// pgo_out_if
// Output channel: one corrected pixel pair per handshake, valid/ready.
// ----------------------------------------------------------------------------
interface pgo_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_even;
    logic [7:0] pixel_odd;

    modport source (
        output valid, pixel_even, pixel_odd,
        input  ready
    );

    modport sink (
        input  valid, pixel_even, pixel_odd,
        output ready
    );
endinterface

/* rtl/pgo_coef_scale.sv */
// ----------------------------------------------------------------------------
// pgo_coef_scale
// Scales one loaded coefficient by the page gain: 24x24 multiply, then
// round half to even by 2^16 and saturate to 24 bits. Two stages.
// ----------------------------------------------------------------------------
module pgo_coef_scale (
    input  logic                    clk,
    input  pgo_pkg::pgo_scale_ctl_t ctl,
    input  logic signed [23:0]      coef,
    input  logic signed [23:0]      agc,
    output logic signed [23:0]      scaled
);
    import pgo_pkg::*;

    logic signed [47:0] prod_reg;
    logic signed [47:0] prod_next;
    logic signed [32:0] rnd;
    logic signed [23:0] scaled_reg;
    logic signed [23:0] scaled_next;

    // Stage 1: full product
    assign prod_next = 48'(coef) * 48'(agc);

    always_ff @(posedge clk)
    begin
        if (ctl.s1_en)
        begin
            prod_reg <= prod_next;
        end
    end

    // Stage 2: round and saturate
    always_comb
    begin
        rnd = rne_shr16(prod_reg);
        if (rnd[32:23] != {10{rnd[32]}})
        begin
            scaled_next = rnd[32] ? COEF_MIN : COEF_MAX;
        end
        else
        begin
            scaled_next = rnd[23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s2_en)
        begin
            scaled_reg <= scaled_next;
        end
    end

    assign scaled = scaled_reg;

endmodule

/* rtl/pgo_lane.sv */
// ----------------------------------------------------------------------------
// pgo_lane
// One correction lane: holds the gain/offset table of its column parity,
// reads the column entry, forms pixel*gain + offset*2^8 and rounds/clamps
// it to eight bits.
// ----------------------------------------------------------------------------
module pgo_lane #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                   clk,
    input  pgo_pkg::pgo_lane_ctl_t ctl,
    input  logic [ADDR_W-1:0]      addr,
    input  logic signed [23:0]     wr_gain,
    input  logic signed [23:0]     wr_offset,
    input  logic [11:0]            pix,
    output logic [7:0]             pixel
);
    import pgo_pkg::*;

    logic [47:0]        mem [DEPTH];
    logic [47:0]        rd_data_reg;
    logic [11:0]        pix_reg;
    logic signed [23:0] gain3;
    logic signed [23:0] offset3;
    logic signed [12:0] pix_s;
    logic signed [36:0] sum_next;
    logic signed [36:0] sum_reg;
    logic signed [32:0] rnd;

    // Table: one port, write for loads, registered read for pixels
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= {wr_gain, wr_offset};
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s3_en)
        begin
            pix_reg <= pix;
        end
    end

    // Stage 4: exact sum at a 16-bit fraction
    assign gain3    = rd_data_reg[47:24];
    assign offset3  = rd_data_reg[23:0];
    assign pix_s    = {1'b0, pix_reg};
    assign sum_next = 37'(pix_s) * 37'(gain3) + (37'(offset3) <<< 8);

    always_ff @(posedge clk)
    begin
        if (ctl.s4_en)
        begin
            sum_reg <= sum_next;
        end
    end

    // Round half to even, clamp to 0..255
    always_comb
    begin
        rnd = rne_shr16(48'(sum_reg));
        if (rnd[32])
        begin
            pixel = 8'd0;
        end
        else if (|rnd[31:8])
        begin
            pixel = 8'hff;
        end
        else
        begin
            pixel = rnd[7:0];
        end
    end

endmodule

/* rtl/packed12_gain_offset_to_u8.sv */
// ----------------------------------------------------------------------------
// packed12_gain_offset_to_u8
// Per-column gain/offset correction of packed 12-bit pixel pairs to 8 bits.
// An accepted item passes the stage 1 to 4 registers, then the output register.
// Throughput: one item per cycle unless out_ch stalls; loads use a slot, no result.
// The rate is set by the single-port lane tables: one read or one write a cycle.
// Reset: pipeline emptied, column count 0, page gain 1.0; the coefficient
// tables are not cleared and hold garbage until loaded.
// ----------------------------------------------------------------------------
module packed12_gain_offset_to_u8 #(
    parameter int MAX_LINE_WIDTH = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               agc_wr_en,
    input  logic signed [23:0] agc_wr_data,
    pgo_in_if.sink             in_ch,
    pgo_out_if.source          out_ch
);
    import pgo_pkg::*;

    localparam int DEPTH  = (MAX_LINE_WIDTH + 1) / 2;
    localparam int HALF   = MAX_LINE_WIDTH / 2;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [ADDR_W-1:0] COL_LAST = ADDR_W'(HALF - 1);
    localparam logic [15:0]       LINE_W   = 16'(MAX_LINE_WIDTH);

    // Page gain register
    logic signed [23:0] agc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agc_reg <= AGC_RESET;
        end
        else if (agc_wr_en)
        begin
            agc_reg <= agc_wr_data;
        end
    end

    // Stage readiness, back to front
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, s4_valid_next, out_valid_next;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic accept;

    assign rdy5   = !out_valid_reg || out_ch.ready;
    assign rdy4   = !s4_valid_reg || rdy5;
    assign rdy3   = !s3_valid_reg || rdy4;
    assign rdy2   = !s2_valid_reg || rdy3;
    assign rdy1   = !s1_valid_reg || rdy2;
    assign accept = in_ch.valid && rdy1;

    assign in_ch.ready = rdy1;

    // Column count, advanced on each accepted pixel pair
    logic [ADDR_W-1:0] pair_column_reg;
    logic [ADDR_W-1:0] pair_column_next;
    logic [ADDR_W-1:0] col_cur;
    logic [ADDR_W-1:0] col_inc;

    always_comb
    begin
        col_cur = in_ch.line_start ? '0 : pair_column_reg;
        col_inc = (col_cur == COL_LAST) ? '0 : col_cur + 1'b1;
        pair_column_next = pair_column_reg;
        if (accept && (in_ch.cmd == CMD_PROCESS))
        begin
            pair_column_next = col_inc;
        end
    end

    // Unpack the pixel pair
    logic [7:0]  b0, b1, b2;
    logic [11:0] pix_e_in, pix_o_in;
    logic [7:0]  b1_hi;

    always_comb
    begin
        b0       = in_ch.packed_pair[7:0];
        b1       = in_ch.packed_pair[15:8];
        b2       = in_ch.packed_pair[23:16];
        b1_hi    = (b1 & NIB_HI) >> NIB_SHIFT;
        pix_e_in = {4'((b1 & NIB_LO)), b0};
        pix_o_in = {b2, b1_hi[3:0]};
    end

    logic              s1_cmd_reg, s2_cmd_reg;
    logic [ADDR_W-1:0] s1_col_reg, s2_col_reg;
    logic [11:0]       s1_pix_e_reg, s1_pix_o_reg, s2_pix_e_reg, s2_pix_o_reg;
    logic [11:0]       s1_idx_reg, s2_idx_reg;

    // Valid chain
    always_comb
    begin
        s1_valid_next  = rdy1 ? in_ch.valid : s1_valid_reg;
        s2_valid_next  = rdy2 ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = rdy3 ? (s2_valid_reg && (s2_cmd_reg == CMD_PROCESS)) : s3_valid_reg;
        s4_valid_next  = rdy4 ? s3_valid_reg : s4_valid_reg;
        out_valid_next = rdy5 ? s4_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            pair_column_reg <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            s2_valid_reg    <= s2_valid_next;
            s3_valid_reg    <= s3_valid_next;
            s4_valid_reg    <= s4_valid_next;
            out_valid_reg   <= out_valid_next;
            pair_column_reg <= pair_column_next;
        end
    end

    // Stage 1 and 2 payload
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_cmd_reg   <= in_ch.cmd;
            s1_col_reg   <= col_cur;
            s1_pix_e_reg <= pix_e_in;
            s1_pix_o_reg <= pix_o_in;
            s1_idx_reg   <= in_ch.coef_index;
        end
        if (rdy2)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_col_reg   <= s1_col_reg;
            s2_pix_e_reg <= s1_pix_e_reg;
            s2_pix_o_reg <= s1_pix_o_reg;
            s2_idx_reg   <= s1_idx_reg;
        end
    end

    // Coefficient scaling, gain and offset side by side
    pgo_scale_ctl_t     scale_ctl;
    logic signed [23:0] gain_scaled;
    logic signed [23:0] offset_scaled;

    assign scale_ctl.s1_en = rdy1;
    assign scale_ctl.s2_en = rdy2;

    pgo_coef_scale u_scale_gain (
        .clk    (clk),
        .ctl    (scale_ctl),
        .coef   (in_ch.coef_gain),
        .agc    (agc_reg),
        .scaled (gain_scaled)
    );

    pgo_coef_scale u_scale_offset (
        .clk    (clk),
        .ctl    (scale_ctl),
        .coef   (in_ch.coef_offset),
        .agc    (agc_reg),
        .scaled (offset_scaled)
    );

    // Table address and lane controls for the item leaving stage 2
    logic [ADDR_W+10:0] idx_wide;
    logic [ADDR_W-1:0]  lane_addr;
    logic               do_load, do_read, idx_ok;
    pgo_lane_ctl_t      ctl_even, ctl_odd;

    always_comb
    begin
        idx_wide  = {{ADDR_W{1'b0}}, s2_idx_reg[11:1]};
        idx_ok    = {4'b0, s2_idx_reg} < LINE_W;
        do_load   = rdy3 && s2_valid_reg && (s2_cmd_reg == CMD_LOAD) && idx_ok;
        do_read   = rdy3 && s2_valid_reg && (s2_cmd_reg == CMD_PROCESS);
        lane_addr = (s2_cmd_reg == CMD_LOAD) ? idx_wide[ADDR_W-1:0] : s2_col_reg;

        ctl_even.s3_en = rdy3;
        ctl_even.rd_en = do_read;
        ctl_even.wr_en = do_load && !s2_idx_reg[0];
        ctl_even.s4_en = rdy4;

        ctl_odd.s3_en  = rdy3;
        ctl_odd.rd_en  = do_read;
        ctl_odd.wr_en  = do_load && s2_idx_reg[0];
        ctl_odd.s4_en  = rdy4;
    end

    // Even and odd column lanes
    logic [7:0] lane_even_pix, lane_odd_pix;

    pgo_lane #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_lane_even (
        .clk       (clk),
        .ctl       (ctl_even),
        .addr      (lane_addr),
        .wr_gain   (gain_scaled),
        .wr_offset (offset_scaled),
        .pix       (s2_pix_e_reg),
        .pixel     (lane_even_pix)
    );

    pgo_lane #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_lane_odd (
        .clk       (clk),
        .ctl       (ctl_odd),
        .addr      (lane_addr),
        .wr_gain   (gain_scaled),
        .wr_offset (offset_scaled),
        .pix       (s2_pix_o_reg),
        .pixel     (lane_odd_pix)
    );

    // Merge: both lane results into the output register
    logic [7:0] out_even_reg, out_odd_reg;

    always_ff @(posedge clk)
    begin
        if (rdy5)
        begin
            out_even_reg <= lane_even_pix;
            out_odd_reg  <= lane_odd_pix;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pixel_even = out_even_reg;
    assign out_ch.pixel_odd  = out_odd_reg;

    // Checks
    a_tbl_port: assert property (@(posedge clk) disable iff (!rst_n)
        !((ctl_even.wr_en || ctl_odd.wr_en) && do_read))
        else $error("table read and write in the same cycle");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rdy3 && s2_valid_reg && (s2_cmd_reg == CMD_LOAD)) |=> !s3_valid_reg)
        else $error("load item entered the result path");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        pair_column_reg <= COL_LAST)
        else $error("column count out of range");

    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_ch.cmd == CMD_PROCESS) && !in_ch.line_start
            && (pair_column_reg != COL_LAST))
        |=> (pair_column_reg == $past(pair_column_reg) + 1'b1))
        else $error("column count did not advance");

endmodule
